>>> sv/conv3x3_register_device_assert.svh
// Assertion macros shared by the convolution register device RTL.
// Expects clk and arst_n to be visible in the module that uses them.
`ifndef CONV3X3_REGISTER_DEVICE_ASSERT_SVH
`define CONV3X3_REGISTER_DEVICE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CV3_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CV3_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/cv3_pkg.sv
// Package for the convolution register device: geometry, address map,
// controller states and the command and status structs. No dependencies.
package cv3_pkg;

	localparam int IMG_SIDE  = 8;
	localparam int KER_SIDE  = 3;
	localparam int WIN_BYTES = 128;
	localparam int OUT_SIDE  = IMG_SIDE - KER_SIDE + 1;

	localparam int ADDR_W = $clog2(WIN_BYTES);
	localparam int DATA_W = 8;
	localparam int ORC_W  = $clog2(OUT_SIDE);
	localparam int KER_W  = $clog2(KER_SIDE);

	localparam logic [ADDR_W-1:0] KERNEL_BASE  = ADDR_W'(0);
	localparam logic [ADDR_W-1:0] IMAGE_BASE   = ADDR_W'(9);
	localparam logic [ADDR_W-1:0] RESULT_BASE  = ADDR_W'(73);
	localparam logic [ADDR_W-1:0] CONTROL_ADDR = ADDR_W'(109);

	localparam logic [DATA_W-1:0] CTL_START = DATA_W'(1);
	localparam logic [DATA_W-1:0] CTL_DONE  = DATA_W'(2);

	localparam logic [0:0] CMD_READ  = 1'b0;
	localparam logic [0:0] CMD_WRITE = 1'b1;

	// Division of a byte by nine as a multiplication by 57 and a shift by 9.
	localparam int QM_W      = 16;
	localparam int DIV_MUL   = 57;
	localparam int DIV_SHIFT = 9;

	typedef enum logic [2:0] {
		CV3_IDLE,
		CV3_RDWAIT,
		CV3_CONV,
		CV3_DRAIN,
		CV3_FINISH
	} cv3_state_t;

	typedef struct packed {
		logic idle;
		logic host_wr;
		logic host_rd;
		logic conv_start;
		logic conv_issue;
		logic fin_wr;
		logic load_zero;
		logic load_mem;
	} cv3_cmd_t;

	typedef struct packed {
		logic ctl_start;
		logic ctl_done;
		logic issue_last;
		logic pipe_busy;
	} cv3_stat_t;

endpackage

>>> sv/cv3_ctrl.sv
// Controller state machine of the convolution register device.
// Depends on cv3_pkg and the assertion macro header.
`include "conv3x3_register_device_assert.svh"

module cv3_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              command,
	input  cv3_pkg::cv3_stat_t stat,
	output cv3_pkg::cv3_cmd_t  cmd
);

	cv3_pkg::cv3_state_t state_q;
	cv3_pkg::cv3_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cv3_pkg::CV3_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			cv3_pkg::CV3_IDLE: begin
				cmd.idle = 1'b1;
				if (in_fire) begin
					priority if (command == cv3_pkg::CMD_WRITE) begin
						cmd.host_wr   = 1'b1;
						cmd.load_zero = 1'b1;
					end else if (stat.ctl_start) begin
						cmd.load_zero  = 1'b1;
						cmd.conv_start = 1'b1;
						state_d        = cv3_pkg::CV3_CONV;
					end else if (stat.ctl_done) begin
						cmd.host_rd = 1'b1;
						state_d     = cv3_pkg::CV3_RDWAIT;
					end else begin
						cmd.load_zero = 1'b1;
					end
				end
			end
			cv3_pkg::CV3_RDWAIT: begin
				cmd.load_mem = 1'b1;
				state_d      = cv3_pkg::CV3_IDLE;
			end
			cv3_pkg::CV3_CONV: begin
				cmd.conv_issue = 1'b1;
				if (stat.issue_last) begin
					state_d = cv3_pkg::CV3_DRAIN;
				end
			end
			cv3_pkg::CV3_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_d = cv3_pkg::CV3_FINISH;
				end
			end
			cv3_pkg::CV3_FINISH: begin
				cmd.fin_wr = 1'b1;
				state_d    = cv3_pkg::CV3_IDLE;
			end
			default: begin
				state_d = cv3_pkg::CV3_IDLE;
			end
		endcase
	end

	`CV3_ASSERT_SAME(a_rdwait_after_read, state_q == cv3_pkg::CV3_RDWAIT, $past(cmd.host_rd), "read wait without a read")
	`CV3_ASSERT_NEXT(a_start_enters_conv, cmd.conv_start, state_q == cv3_pkg::CV3_CONV, "convolution did not start")
	`CV3_ASSERT_SAME(a_finish_drained, state_q == cv3_pkg::CV3_FINISH, !stat.pipe_busy, "finish with pipeline busy")
	`CV3_ASSERT_SAME(a_fire_only_idle, in_fire, state_q == cv3_pkg::CV3_IDLE, "word taken while busy")

endmodule

>>> sv/cv3_datapath.sv
// Datapath of the convolution register device: the byte window with its
// valid bits, the control shadow and the multiply-accumulate pipeline. Uses cv3_pkg.
module cv3_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cv3_pkg::cv3_cmd_t            cmd,
	input  logic [cv3_pkg::ADDR_W-1:0]   address,
	input  logic [cv3_pkg::DATA_W-1:0]   write_value,
	output cv3_pkg::cv3_stat_t           stat,
	output logic [cv3_pkg::DATA_W-1:0]   rd_data
);

	localparam logic [cv3_pkg::ADDR_W-1:0] IMG_SIDE_A = cv3_pkg::ADDR_W'(cv3_pkg::IMG_SIDE);
	localparam logic [cv3_pkg::ADDR_W-1:0] KER_SIDE_A = cv3_pkg::ADDR_W'(cv3_pkg::KER_SIDE);
	localparam logic [cv3_pkg::ADDR_W-1:0] OUT_SIDE_A = cv3_pkg::ADDR_W'(cv3_pkg::OUT_SIDE);
	localparam logic [cv3_pkg::ORC_W-1:0]  OUT_LAST   = cv3_pkg::ORC_W'(cv3_pkg::OUT_SIDE - 1);
	localparam logic [cv3_pkg::KER_W-1:0]  KER_LAST   = cv3_pkg::KER_W'(cv3_pkg::KER_SIDE - 1);
	localparam logic [cv3_pkg::QM_W-1:0]   DIV_MUL_Q  = cv3_pkg::QM_W'(cv3_pkg::DIV_MUL);

	logic [cv3_pkg::DATA_W-1:0] mem_q [cv3_pkg::WIN_BYTES];
	logic [cv3_pkg::WIN_BYTES-1:0] vld_q;
	logic [cv3_pkg::DATA_W-1:0] ctl_q;

	logic [cv3_pkg::ORC_W-1:0] out_r_q, out_c_q;
	logic [cv3_pkg::KER_W-1:0] k_r_q, k_c_q;

	logic [cv3_pkg::ADDR_W-1:0] pix_addr, ker_addr, res_addr, ra_a;
	logic                       tap_first, tap_last;

	logic                       we;
	logic [cv3_pkg::ADDR_W-1:0] wa;
	logic [cv3_pkg::DATA_W-1:0] wd;

	logic [cv3_pkg::DATA_W-1:0] rda_q, rdb_q;
	logic                       rva_q, rvb_q;
	logic [cv3_pkg::DATA_W-1:0] pix_byte, ker_byte;
	logic [2*cv3_pkg::DATA_W-1:0] prod_full;
	logic [cv3_pkg::QM_W-1:0]   quo_full;

	logic                       tap_s1, first_s1, last_s1;
	logic [cv3_pkg::ADDR_W-1:0] res_s1;
	logic                       tap_s2, first_s2, last_s2;
	logic [cv3_pkg::ADDR_W-1:0] res_s2;
	logic [cv3_pkg::DATA_W-1:0] prod_s2;
	logic [cv3_pkg::DATA_W-1:0] acc_q;
	logic                       done_s3;
	logic [cv3_pkg::ADDR_W-1:0] res_s3;
	logic                       wr_s4;
	logic [cv3_pkg::ADDR_W-1:0] res_s4;
	logic [cv3_pkg::DATA_W-1:0] quo_s4;

	assign pix_addr = cv3_pkg::IMAGE_BASE
		+ (cv3_pkg::ADDR_W'(out_r_q) + cv3_pkg::ADDR_W'(k_r_q)) * IMG_SIDE_A
		+ cv3_pkg::ADDR_W'(out_c_q) + cv3_pkg::ADDR_W'(k_c_q);
	assign ker_addr = cv3_pkg::KERNEL_BASE + cv3_pkg::ADDR_W'(k_r_q) * KER_SIDE_A
		+ cv3_pkg::ADDR_W'(k_c_q);
	assign res_addr = cv3_pkg::RESULT_BASE + cv3_pkg::ADDR_W'(out_r_q) * OUT_SIDE_A
		+ cv3_pkg::ADDR_W'(out_c_q);
	assign ra_a     = cmd.host_rd ? address : pix_addr;

	assign tap_first = (k_r_q == '0) && (k_c_q == '0);
	assign tap_last  = (k_r_q == KER_LAST) && (k_c_q == KER_LAST);

	always_comb begin
		we = 1'b0;
		wa = address;
		wd = write_value;
		priority if (cmd.host_wr) begin
			we = 1'b1;
		end else if (cmd.fin_wr) begin
			we = 1'b1;
			wa = cv3_pkg::CONTROL_ADDR;
			wd = cv3_pkg::CTL_DONE;
		end else if (wr_s4) begin
			we = 1'b1;
			wa = res_s4;
			wd = quo_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rda_q <= mem_q[ra_a];
		rdb_q <= mem_q[ker_addr];
		rva_q <= vld_q[ra_a];
		rvb_q <= vld_q[ker_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			ctl_q <= '0;
		end else begin
			if (we) begin
				vld_q[wa] <= 1'b1;
			end
			if (we && (wa == cv3_pkg::CONTROL_ADDR)) begin
				ctl_q <= wd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_r_q <= '0;
			out_c_q <= '0;
			k_r_q   <= '0;
			k_c_q   <= '0;
		end else if (cmd.conv_start) begin
			out_r_q <= '0;
			out_c_q <= '0;
			k_r_q   <= '0;
			k_c_q   <= '0;
		end else if (cmd.conv_issue) begin
			if (k_c_q != KER_LAST) begin
				k_c_q <= k_c_q + cv3_pkg::KER_W'(1);
			end else begin
				k_c_q <= '0;
				if (k_r_q != KER_LAST) begin
					k_r_q <= k_r_q + cv3_pkg::KER_W'(1);
				end else begin
					k_r_q <= '0;
					if (out_c_q != OUT_LAST) begin
						out_c_q <= out_c_q + cv3_pkg::ORC_W'(1);
					end else begin
						out_c_q <= '0;
						out_r_q <= out_r_q + cv3_pkg::ORC_W'(1);
					end
				end
			end
		end
	end

	assign pix_byte  = rva_q ? rda_q : '0;
	assign ker_byte  = rvb_q ? rdb_q : '0;
	assign prod_full = (2*cv3_pkg::DATA_W)'(pix_byte) * (2*cv3_pkg::DATA_W)'(ker_byte);
	assign quo_full  = cv3_pkg::QM_W'(acc_q) * DIV_MUL_Q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s1  <= 1'b0;
			tap_s2  <= 1'b0;
			done_s3 <= 1'b0;
			wr_s4   <= 1'b0;
		end else begin
			tap_s1  <= cmd.conv_issue;
			tap_s2  <= tap_s1;
			done_s3 <= tap_s2 && last_s2;
			wr_s4   <= done_s3;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= tap_first;
		last_s1  <= tap_last;
		res_s1   <= res_addr;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		res_s2   <= res_s1;
		prod_s2  <= prod_full[cv3_pkg::DATA_W-1:0];
		if (tap_s2) begin
			acc_q <= (first_s2 ? '0 : acc_q) + prod_s2;
		end
		res_s3   <= res_s2;
		res_s4   <= res_s3;
		quo_s4   <= cv3_pkg::DATA_W'(quo_full >> cv3_pkg::DIV_SHIFT);
	end

	assign stat.ctl_start  = (ctl_q == cv3_pkg::CTL_START);
	assign stat.ctl_done   = (ctl_q == cv3_pkg::CTL_DONE);
	assign stat.issue_last = tap_last && (out_r_q == OUT_LAST) && (out_c_q == OUT_LAST);
	assign stat.pipe_busy  = tap_s1 || tap_s2 || done_s3 || wr_s4;
	assign rd_data         = pix_byte;

endmodule

>>> sv/conv3x3_register_device.sv
// Top level of the convolution register device: word handshakes and the
// output register. Instantiates cv3_ctrl and cv3_datapath; uses cv3_pkg.
//
// Each input word is a bus access (command, address, write_value) and gives
// exactly one output word, read_value. Both channels use valid and stall.
// A write stores its byte and returns 0 in the cycle after acceptance; a
// new write can be taken every cycle while the receiver does not stall. A
// read while control is 2 returns the addressed byte via the memory read
// register and the output register, stalling input in the read-wait state.
// A read while control is 1 also returns 0 and starts the convolution: 36
// outputs of 9 taps each, one tap per cycle through the two read ports of
// the window memory, and the input stalls until the results and control
// value 2 are written. Other reads return 0 too. A finished word waits in
// the output register while the receiver stalls; the next word is accepted
// once it leaves. Reset clears the per-byte valid bits, so the whole window
// reads as zero at once, with no clearing pass.
module conv3x3_register_device (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       command,
	input  logic [cv3_pkg::ADDR_W-1:0] address,
	input  logic [cv3_pkg::DATA_W-1:0] write_value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [cv3_pkg::DATA_W-1:0] read_value
);

	cv3_pkg::cv3_cmd_t  cmd;
	cv3_pkg::cv3_stat_t stat;
	logic [cv3_pkg::DATA_W-1:0] rd_data;
	logic                       in_fire;
	logic                       out_valid_q;
	logic [cv3_pkg::DATA_W-1:0] read_value_q;

	assign in_stall = !cmd.idle || (out_valid_q && out_stall);
	assign in_fire  = in_valid && !in_stall;

	cv3_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.command (command),
		.stat    (stat),
		.cmd     (cmd)
	);

	cv3_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.address     (address),
		.write_value (write_value),
		.stat        (stat),
		.rd_data     (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_zero || cmd.load_mem) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_zero) begin
			read_value_q <= '0;
		end else if (cmd.load_mem) begin
			read_value_q <= rd_data;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for conv3x3_register_device: drives bus words through
// a queue-fed driver, mirrors the register window to predict every read_value,
// and checks the results in order. Depends on cv3_pkg and the device RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IMG_SIDE  = cv3_pkg::IMG_SIDE;
	localparam int KER_SIDE  = cv3_pkg::KER_SIDE;
	localparam int WIN_BYTES = cv3_pkg::WIN_BYTES;
	localparam int OUT_SIDE  = cv3_pkg::OUT_SIDE;
	localparam int ADDR_W    = cv3_pkg::ADDR_W;
	localparam int DATA_W    = cv3_pkg::DATA_W;

	localparam logic [ADDR_W-1:0] KERNEL_BASE  = cv3_pkg::KERNEL_BASE;
	localparam logic [ADDR_W-1:0] IMAGE_BASE   = cv3_pkg::IMAGE_BASE;
	localparam logic [ADDR_W-1:0] RESULT_BASE  = cv3_pkg::RESULT_BASE;
	localparam logic [ADDR_W-1:0] CONTROL_ADDR = cv3_pkg::CONTROL_ADDR;
	localparam logic [DATA_W-1:0] CTL_START    = cv3_pkg::CTL_START;
	localparam logic [DATA_W-1:0] CTL_DONE     = cv3_pkg::CTL_DONE;
	localparam logic [0:0]        CMD_READ     = cv3_pkg::CMD_READ;
	localparam logic [0:0]        CMD_WRITE    = cv3_pkg::CMD_WRITE;

	localparam int SUM_DIVISOR  = 9;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int TAIL_CYCLES  = 8;
	localparam int RESULT_BYTES = OUT_SIDE * OUT_SIDE;

	typedef struct packed {
		logic [0:0]        command;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] write_value;
	} bus_word_t;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic              command     = CMD_READ;
	logic [ADDR_W-1:0] address     = '0;
	logic [DATA_W-1:0] write_value = '0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic [DATA_W-1:0] read_value;

	bus_word_t         pending_words[$];
	logic [DATA_W-1:0] expected_reads[$];
	logic [DATA_W-1:0] window_mirror[WIN_BYTES];

	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	int error_count        = 0;
	int cycle_count        = 0;
	int read_count         = 0;
	int write_count        = 0;
	int convolution_count  = 0;

	conv3x3_register_device dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.address     (address),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_value  (read_value)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	function automatic void convolve_mirror();
		logic [DATA_W-1:0] acc;
		logic [15:0]       prod;
		for (int r = 0; r < OUT_SIDE; r++) begin
			for (int c = 0; c < OUT_SIDE; c++) begin
				acc = '0;
				for (int kr = 0; kr < KER_SIDE; kr++) begin
					for (int kc = 0; kc < KER_SIDE; kc++) begin
						prod = 16'(window_mirror[ADDR_W'(IMAGE_BASE + (r + kr) * IMG_SIDE
							+ c + kc)]) *
							16'(window_mirror[ADDR_W'(KERNEL_BASE + kr * KER_SIDE + kc)]);
						acc = acc + prod[DATA_W-1:0];
					end
				end
				window_mirror[ADDR_W'(RESULT_BASE + r * OUT_SIDE + c)] =
					DATA_W'(acc / SUM_DIVISOR);
			end
		end
		window_mirror[CONTROL_ADDR] = CTL_DONE;
	endfunction

	function automatic logic [DATA_W-1:0] predict_access(bus_word_t w);
		logic [DATA_W-1:0] ctl;
		logic [DATA_W-1:0] rv;
		rv = '0;
		if (w.command == CMD_WRITE) begin
			window_mirror[w.address] = w.write_value;
			write_count++;
		end else begin
			read_count++;
			ctl = window_mirror[CONTROL_ADDR];
			if (ctl == CTL_START) begin
				convolve_mirror();
				convolution_count++;
			end else if (ctl == CTL_DONE) begin
				rv = window_mirror[w.address];
			end
		end
		return rv;
	endfunction

	// Driver: a presented word is held unchanged until it is taken.
	always @(posedge clk) begin
		logic fire;
		logic next_valid;
		fire = in_valid && !in_stall;
		if (fire) begin
			expected_reads.push_back(predict_access(pending_words[0]));
			void'(pending_words.pop_front());
		end
		if (in_valid && !fire)
			next_valid = 1'b1;
		else
			next_valid = (pending_words.size() != 0) &&
				($urandom_range(99) >= sender_idle_pct);
		if (next_valid) begin
			command     <= pending_words[0].command;
			address     <= pending_words[0].address;
			write_value <= pending_words[0].write_value;
		end
		in_valid <= next_valid;
	end

	// Monitor: compares each word taken from the device with the oldest prediction.
	always @(posedge clk) begin
		logic [DATA_W-1:0] want;
		if (out_valid && !out_stall) begin
			if (expected_reads.size() == 0) begin
				$error("read_value: expected nothing, got %0d", read_value);
				error_count++;
			end else begin
				want = expected_reads.pop_front();
				if (read_value !== want) begin
					$error("read_value: expected %0d, got %0d", want, read_value);
					error_count++;
				end
			end
		end
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	task automatic push_word(logic [0:0] cmd, logic [ADDR_W-1:0] addr,
		logic [DATA_W-1:0] val);
		bus_word_t w;
		w.command     = cmd;
		w.address     = addr;
		w.write_value = val;
		pending_words.push_back(w);
	endtask

	task automatic wait_for_drain();
		while (pending_words.size() != 0 || in_valid || expected_reads.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(int idle_pct, int stall_pct, int word_target);
		int added;
		int n;
		logic [DATA_W-1:0] val;
		wait_for_drain();
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		added = 0;
		while (added < word_target) begin
			if ($urandom_range(99) < 75) begin
				n = $urandom_range(1, 12);
				for (int i = 0; i < n; i++) begin
					case ($urandom_range(7))
						0: val = '0;
						1: val = '1;
						default: val = DATA_W'($urandom);
					endcase
					push_word(CMD_WRITE, ADDR_W'($urandom_range(0, RESULT_BASE - 1)), val);
				end
				push_word(CMD_WRITE, CONTROL_ADDR, CTL_START);
				push_word(CMD_READ, ADDR_W'($urandom_range(0, WIN_BYTES - 1)),
					DATA_W'($urandom));
				added += n + 2;
				n = $urandom_range(2, 8);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(1))
						push_word(CMD_READ,
							ADDR_W'(RESULT_BASE + $urandom_range(0, RESULT_BYTES - 1)),
							DATA_W'($urandom));
					else
						push_word($urandom_range(3) == 0 ? CMD_WRITE : CMD_READ,
							ADDR_W'($urandom_range(0, WIN_BYTES - 1)), DATA_W'($urandom));
				end
				added += n;
			end else begin
				if ($urandom_range(3) == 0)
					push_word(CMD_WRITE, CONTROL_ADDR, DATA_W'($urandom_range(0, 3)));
				else
					push_word(1'($urandom_range(1)), ADDR_W'($urandom_range(0, WIN_BYTES - 1)),
						DATA_W'($urandom));
				added++;
			end
		end
	endtask

	initial begin
		for (int i = 0; i < WIN_BYTES; i++)
			window_mirror[ADDR_W'(i)] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Saturated kernel and image corners, a result-area write and every control case.
		push_word(CMD_READ, ADDR_W'(0), 8'hFF);
		push_word(CMD_WRITE, ADDR_W'(WIN_BYTES - 1), 8'hFF);
		for (int i = 0; i < KER_SIDE * KER_SIDE; i++)
			push_word(CMD_WRITE, ADDR_W'(KERNEL_BASE + i), 8'hFF);
		push_word(CMD_WRITE, IMAGE_BASE, 8'hFF);
		push_word(CMD_WRITE, ADDR_W'(RESULT_BASE - 1), 8'hFF);
		push_word(CMD_WRITE, RESULT_BASE, 8'hAA);
		push_word(CMD_WRITE, CONTROL_ADDR, CTL_START);
		push_word(CMD_READ, ADDR_W'(WIN_BYTES - 1), 8'h00);
		push_word(CMD_READ, RESULT_BASE, 8'h00);
		push_word(CMD_READ, ADDR_W'(RESULT_BASE + RESULT_BYTES - 1), 8'h00);
		push_word(CMD_READ, ADDR_W'(WIN_BYTES - 1), 8'h00);
		push_word(CMD_READ, CONTROL_ADDR, 8'h00);
		push_word(CMD_WRITE, CONTROL_ADDR, 8'h03);
		push_word(CMD_READ, IMAGE_BASE, 8'h00);
		push_word(CMD_WRITE, CONTROL_ADDR, CTL_DONE);
		push_word(CMD_READ, ADDR_W'(RESULT_BASE - 1), 8'h00);
		push_word(CMD_WRITE, CONTROL_ADDR, 8'h00);

		run_phase(0, 0, 212);
		run_phase(52, 0, 212);
		run_phase(0, 52, 212);
		run_phase(31, 31, 212);
		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d bus words (%0d reads, %0d writes) including %0d convolutions,",
			read_count + write_count, read_count, write_count, convolution_count);
		$display("under free-running, sender-idle, receiver-stall and mixed handshake pressure.");
		if (error_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
